>>> sv/h2fp_pkg.sv
package h2fp_pkg;

    // result kinds
    localparam logic [3:0] KIND_HEADER      = 4'd0;
    localparam logic [3:0] KIND_SETTING     = 4'd1;
    localparam logic [3:0] KIND_SETTINGS_ACK = 4'd2;
    localparam logic [3:0] KIND_HEADERS_REQ = 4'd3;
    localparam logic [3:0] KIND_PING_ACK    = 4'd4;
    localparam logic [3:0] KIND_RST_END     = 4'd5;
    localparam logic [3:0] KIND_GOAWAY_END  = 4'd6;
    localparam logic [3:0] KIND_WINDOW_UPD  = 4'd7;
    localparam logic [3:0] KIND_DATA_END    = 4'd8;
    localparam logic [3:0] KIND_SIZE_ERROR  = 4'd9;

    // frame types
    localparam logic [7:0] TYPE_DATA       = 8'h00;
    localparam logic [7:0] TYPE_RST_STREAM = 8'h03;
    localparam logic [7:0] TYPE_SETTINGS   = 8'h04;
    localparam logic [7:0] TYPE_PING       = 8'h06;
    localparam logic [7:0] TYPE_GOAWAY     = 8'h07;
    localparam logic [7:0] TYPE_WINDOW_UPD = 8'h08;

    localparam logic [7:0] FLAG_END_STREAM = 8'h01;

    localparam logic [3:0] HEADER_LAST   = 4'd8;
    localparam logic [2:0] SETTING_BYTES = 3'd6;
    localparam int         MAX_RESULTS   = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [7:0]  frame_kind;
        logic [7:0]  frame_bits;
        logic        last;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] item;
        logic [1:0]                count;
    } batch_t;

    function automatic result_t make_result(input logic [3:0] kind,
                                            input logic [31:0] word_a,
                                            input logic [31:0] word_b,
                                            input logic [7:0] frame_kind,
                                            input logic [7:0] frame_bits);
        result_t r;
        r.kind       = kind;
        r.word_a     = word_a;
        r.word_b     = word_b;
        r.frame_kind = frame_kind;
        r.frame_bits = frame_bits;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

>>> sv/h2fp_if.sv
interface h2fp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface h2fp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_bits;
    logic        last;

    modport source (output valid, output kind, output word_a, output word_b,
                    output frame_kind, output frame_bits, output last,
                    input ready);
    modport sink   (input valid, input kind, input word_a, input word_b,
                    input frame_kind, input frame_bits, input last,
                    output ready);
endinterface

>>> sv/h2fp_decode.sv
module h2fp_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output h2fp_pkg::batch_t    batch
);

    logic        halted_reg, halted_next;
    logic        in_payload_reg, in_payload_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [23:0] frame_length_reg, frame_length_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  frame_flags_reg, frame_flags_next;
    logic [30:0] stream_id_reg, stream_id_next;
    logic [23:0] payload_count_reg, payload_count_next;
    logic [47:0] byte_shift_reg, byte_shift_next;
    logic [31:0] first_word_reg, first_word_next;
    logic [2:0]  entry_count_reg, entry_count_next;
    logic        headers_sent_reg, headers_sent_next;

    h2fp_pkg::result_t [h2fp_pkg::MAX_RESULTS-1:0] items;
    logic [1:0]  n;
    logic        frame_done;
    logic        size_ok;
    logic [47:0] shift;
    logic [2:0]  ec;

    always_comb
    begin
        halted_next        = halted_reg;
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        frame_length_next  = frame_length_reg;
        frame_type_next    = frame_type_reg;
        frame_flags_next   = frame_flags_reg;
        stream_id_next     = stream_id_reg;
        payload_count_next = payload_count_reg;
        byte_shift_next    = byte_shift_reg;
        first_word_next    = first_word_reg;
        entry_count_next   = entry_count_reg;
        headers_sent_next  = headers_sent_reg;
        items      = '0;
        n          = 2'd0;
        frame_done = 1'b0;
        size_ok    = 1'b1;
        shift      = {byte_shift_reg[39:0], rx_byte};
        ec         = entry_count_reg + 3'd1;

        if (!halted_reg)
        begin
            if (!in_payload_reg)
            begin
                if (header_count_reg == 4'd0)
                begin
                    frame_length_next  = '0;
                    stream_id_next     = '0;
                    payload_count_next = '0;
                    byte_shift_next    = '0;
                    first_word_next    = '0;
                    entry_count_next   = '0;
                end
                if (header_count_reg < 4'd3)
                    frame_length_next = {frame_length_next[15:0], rx_byte};
                else if (header_count_reg == 4'd3)
                    frame_type_next = rx_byte;
                else if (header_count_reg == 4'd4)
                    frame_flags_next = rx_byte;
                else
                    stream_id_next = {stream_id_next[22:0], rx_byte};

                if (header_count_reg < h2fp_pkg::HEADER_LAST)
                    header_count_next = header_count_reg + 4'd1;
                else
                begin
                    header_count_next = 4'd0;
                    items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_HEADER,
                        {8'd0, frame_length_next}, {1'b0, stream_id_next},
                        frame_type_next, frame_flags_next);
                    n = n + 2'd1;
                    in_payload_next = 1'b1;
                    frame_done = (frame_length_next == 24'd0);
                end
            end
            else
            begin
                if (frame_type_reg == h2fp_pkg::TYPE_SETTINGS)
                begin
                    if (ec >= h2fp_pkg::SETTING_BYTES)
                    begin
                        items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_SETTING,
                            {16'd0, shift[47:32]}, shift[31:0],
                            frame_type_reg, frame_flags_reg);
                        n = n + 2'd1;
                        entry_count_next = 3'd0;
                        byte_shift_next  = '0;
                    end
                    else
                    begin
                        entry_count_next = ec;
                        byte_shift_next  = shift;
                    end
                end
                else if (payload_count_reg < 24'd4)
                begin
                    // big-endian word, later bytes land lower
                    case (payload_count_reg[1:0])
                        2'd0:    first_word_next[31:24] = first_word_reg[31:24] | rx_byte;
                        2'd1:    first_word_next[23:16] = first_word_reg[23:16] | rx_byte;
                        2'd2:    first_word_next[15:8]  = first_word_reg[15:8]  | rx_byte;
                        default: first_word_next[7:0]   = first_word_reg[7:0]   | rx_byte;
                    endcase
                end
                else if (payload_count_reg < 24'd8 &&
                         frame_type_reg == h2fp_pkg::TYPE_GOAWAY)
                begin
                    case (payload_count_reg[1:0])
                        2'd0:    byte_shift_next[31:24] = byte_shift_reg[31:24] | rx_byte;
                        2'd1:    byte_shift_next[23:16] = byte_shift_reg[23:16] | rx_byte;
                        2'd2:    byte_shift_next[15:8]  = byte_shift_reg[15:8]  | rx_byte;
                        default: byte_shift_next[7:0]   = byte_shift_reg[7:0]   | rx_byte;
                    endcase
                end
                payload_count_next = payload_count_reg + 24'd1;
                frame_done = (payload_count_next == frame_length_reg);
                // bytes consumed equal the length here, so the partial
                // entry count is the length mod 6
                size_ok = (entry_count_next == 3'd0);
            end

            if (frame_done)
            begin
                in_payload_next = 1'b0;
                case (frame_type_next)
                    h2fp_pkg::TYPE_DATA:
                    begin
                        if ((frame_flags_next & h2fp_pkg::FLAG_END_STREAM) != 8'd0)
                        begin
                            items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_DATA_END,
                                32'd0, 32'd0, frame_type_next, frame_flags_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                    end
                    h2fp_pkg::TYPE_RST_STREAM:
                    begin
                        items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_RST_END,
                            first_word_next, {1'b0, stream_id_next},
                            frame_type_next, frame_flags_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    h2fp_pkg::TYPE_SETTINGS:
                    begin
                        if (!size_ok)
                        begin
                            items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_SIZE_ERROR,
                                {8'd0, frame_length_next}, 32'd0,
                                frame_type_next, frame_flags_next);
                            n = n + 2'd1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_SETTINGS_ACK,
                                32'd0, 32'd0, frame_type_next, frame_flags_next);
                            n = n + 2'd1;
                            if (!headers_sent_reg)
                            begin
                                items[n] = h2fp_pkg::make_result(
                                    h2fp_pkg::KIND_HEADERS_REQ, 32'd0, 32'd0,
                                    frame_type_next, frame_flags_next);
                                n = n + 2'd1;
                                headers_sent_next = 1'b1;
                            end
                        end
                    end
                    h2fp_pkg::TYPE_PING:
                    begin
                        items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_PING_ACK,
                            32'd0, 32'd0, frame_type_next, frame_flags_next);
                        n = n + 2'd1;
                    end
                    h2fp_pkg::TYPE_GOAWAY:
                    begin
                        items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_GOAWAY_END,
                            first_word_next, byte_shift_next[31:0],
                            frame_type_next, frame_flags_next);
                        n = n + 2'd1;
                        halted_next = 1'b1;
                    end
                    h2fp_pkg::TYPE_WINDOW_UPD:
                    begin
                        items[n] = h2fp_pkg::make_result(h2fp_pkg::KIND_WINDOW_UPD,
                            first_word_next, 32'd0, frame_type_next, frame_flags_next);
                        n = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        for (int i = 0; i < h2fp_pkg::MAX_RESULTS; i++)
        begin
            items[i].last = (n == 2'(i + 1));
        end
        batch.item  = items;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg        <= 1'b0;
            in_payload_reg    <= 1'b0;
            header_count_reg  <= '0;
            frame_length_reg  <= '0;
            frame_type_reg    <= '0;
            frame_flags_reg   <= '0;
            stream_id_reg     <= '0;
            payload_count_reg <= '0;
            byte_shift_reg    <= '0;
            first_word_reg    <= '0;
            entry_count_reg   <= '0;
            headers_sent_reg  <= 1'b0;
        end
        else if (take)
        begin
            halted_reg        <= halted_next;
            in_payload_reg    <= in_payload_next;
            header_count_reg  <= header_count_next;
            frame_length_reg  <= frame_length_next;
            frame_type_reg    <= frame_type_next;
            frame_flags_reg   <= frame_flags_next;
            stream_id_reg     <= stream_id_next;
            payload_count_reg <= payload_count_next;
            byte_shift_reg    <= byte_shift_next;
            first_word_reg    <= first_word_next;
            entry_count_reg   <= entry_count_next;
            headers_sent_reg  <= headers_sent_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt state cleared without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> batch.count == 2'd0)
        else $error("results produced while halted");

    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg < h2fp_pkg::SETTING_BYTES &&
        (in_payload_reg || header_count_reg <= h2fp_pkg::HEADER_LAST))
        else $error("setting entry or header byte count out of range");
`endif

endmodule

>>> sv/http2_frame_receive_parser.sv
// Latency: results of a byte are offered on the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
// res.ready is high; a byte yielding k results (k up to 3) holds the input until
// its last result leaves the three-entry result buffer, which drains one transfer per cycle while res.ready is high.
// Reset (rst_n, async, active low) clears parser state and empties the buffer.
module http2_frame_receive_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    h2fp_byte_if.sink             rx,
    h2fp_result_if.source         res
);

    h2fp_pkg::batch_t                              batch;
    h2fp_pkg::result_t [h2fp_pkg::MAX_RESULTS-1:0] buf_reg, buf_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       take;
    logic       pop;

    assign pop      = res.valid && res.ready;
    assign rx.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && res.ready);
    assign take     = rx.valid && rx.ready;

    h2fp_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .batch   (batch)
    );

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            // buffer is empty or its last entry leaves this cycle
            buf_next = batch.item;
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign res.valid      = (cnt_reg != 2'd0);
    assign res.kind       = buf_reg[0].kind;
    assign res.word_a     = buf_reg[0].word_a;
    assign res.word_b     = buf_reg[0].word_b;
    assign res.frame_kind = buf_reg[0].frame_kind;
    assign res.frame_bits = buf_reg[0].frame_bits;
    assign res.last       = buf_reg[0].last;

`ifndef SYNTHESIS
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> buf_reg[cnt_reg - 2'd1].last)
        else $error("buffered batch tail not marked last");

    a_batch_contig: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !res.last |=> res.valid)
        else $error("gap inside a batch of results");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        take && cnt_reg == 2'd1 |-> res.ready)
        else $error("pending result overwritten by new batch");
`endif

endmodule
